FILE: rtl/lpv_pkg.sv
// shared types, phase codes and character constants of the local path validator
package lpv_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned MaxLenW  = 15;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned ElemLenW = 2;
  localparam int unsigned OutDataW = 8;

  localparam logic [MaxLenW-1:0] MaxLenReset = MaxLenW'(260);
  localparam logic [CountW-1:0]  CountSat    = {CountW{1'b1}};
  localparam logic [CountW-1:0]  MinCount    = CountW'(3);

  // phase codes
  localparam logic [PhaseW-1:0] PhStart = 4'd0;
  localparam logic [PhaseW-1:0] PhPfx1  = 4'd1;
  localparam logic [PhaseW-1:0] PhPfx2  = 4'd2;
  localparam logic [PhaseW-1:0] PhPfx3  = 4'd3;
  localparam logic [PhaseW-1:0] PhDrive = 4'd4;
  localparam logic [PhaseW-1:0] PhColon = 4'd5;
  localparam logic [PhaseW-1:0] PhSep   = 4'd6;
  localparam logic [PhaseW-1:0] PhBody  = 4'd7;
  localparam logic [PhaseW-1:0] PhDone  = 4'd8;

  // code units
  localparam logic [UnitW-1:0] ChNul      = 16'h0000;
  localparam logic [UnitW-1:0] ChSpace    = 16'h0020;
  localparam logic [UnitW-1:0] ChQuote    = 16'h0022;
  localparam logic [UnitW-1:0] ChStar     = 16'h002A;
  localparam logic [UnitW-1:0] ChDot      = 16'h002E;
  localparam logic [UnitW-1:0] ChSlash    = 16'h002F;
  localparam logic [UnitW-1:0] ChColon    = 16'h003A;
  localparam logic [UnitW-1:0] ChLess     = 16'h003C;
  localparam logic [UnitW-1:0] ChGreater  = 16'h003E;
  localparam logic [UnitW-1:0] ChQuestion = 16'h003F;
  localparam logic [UnitW-1:0] ChBslash   = 16'h005C;
  localparam logic [UnitW-1:0] ChPipe     = 16'h007C;
  localparam logic [UnitW-1:0] ChCtrlEnd  = 16'h0020;

  typedef struct packed {
    logic [PhaseW-1:0]   phase;
    logic [CountW-1:0]   unit_count;
    logic                failed;
    logic [ElemLenW-1:0] elem_len;
    logic                all_dots;
    logic                pending;
  } path_state_t;

  localparam path_state_t PathStateReset = '{
    phase:      PhStart,
    unit_count: '0,
    failed:     1'b0,
    elem_len:   '0,
    all_dots:   1'b1,
    pending:    1'b0
  };

endpackage

FILE: rtl/lpv_step.sv
// next-state and verdict logic for one code unit of the path
module lpv_step import lpv_pkg::*; (
  input  path_state_t        state_i,
  input  logic [UnitW-1:0]   unit_i,
  input  logic [MaxLenW-1:0] max_len_i,
  output path_state_t        state_o,
  output logic               ok_o
);

  logic                is_letter;
  logic                is_sep;
  logic                is_special;
  logic [ElemLenW-1:0] len_inc;
  logic                dots_upd;
  path_state_t         nx;

  always_comb begin
    is_letter  = (unit_i inside {[16'h0041:16'h005A], [16'h0061:16'h007A]});
    is_sep     = (unit_i == ChBslash) || (unit_i == ChSlash);
    is_special = (unit_i inside {ChColon, ChStar, ChQuestion, ChGreater, ChLess,
                                 ChQuote, ChPipe});
    len_inc    = (state_i.elem_len == '1) ? state_i.elem_len
                                          : state_i.elem_len + ElemLenW'(1);
    dots_upd   = state_i.all_dots && (unit_i == ChDot);

    nx = state_i;
    nx.unit_count = (state_i.unit_count == CountSat) ? CountSat
                                                      : state_i.unit_count + CountW'(1);
    if (!state_i.failed) begin
      case (state_i.phase)
        PhStart: begin
          if (unit_i == ChBslash) nx.phase = PhPfx1;
          else if (is_letter) nx.phase = PhColon;
          else nx.failed = 1'b1;
        end
        PhPfx1: begin
          if (unit_i == ChBslash) nx.phase = PhPfx2;
          else nx.failed = 1'b1;
        end
        PhPfx2: begin
          if (unit_i == ChQuestion || unit_i == ChDot) nx.phase = PhPfx3;
          else nx.failed = 1'b1;
        end
        PhPfx3: begin
          // prefix complete, length counts from here
          if (unit_i == ChBslash) begin
            nx.phase      = PhDrive;
            nx.unit_count = '0;
          end else begin
            nx.failed = 1'b1;
          end
        end
        PhDrive: begin
          if (is_letter) nx.phase = PhColon;
          else nx.failed = 1'b1;
        end
        PhColon: begin
          if (unit_i == ChColon) nx.phase = PhSep;
          else nx.failed = 1'b1;
        end
        PhSep: begin
          if (is_sep) begin
            nx.phase    = PhBody;
            nx.elem_len = '0;
            nx.all_dots = 1'b1;
          end else begin
            nx.failed = 1'b1;
          end
        end
        PhBody: begin
          // element ending in space or dot, other than . or .., fails at the separator or nul
          if (state_i.pending && (unit_i == ChNul || is_sep)) nx.failed = 1'b1;
          nx.pending = 1'b0;
          if (unit_i == ChNul) begin
            nx.phase = PhDone;
          end else if (unit_i < ChCtrlEnd || is_special) begin
            nx.failed = 1'b1;
          end else if (is_sep) begin
            nx.elem_len = '0;
            nx.all_dots = 1'b1;
          end else begin
            nx.elem_len = len_inc;
            if (unit_i == ChDot || unit_i == ChSpace) begin
              nx.all_dots = dots_upd;
              if (!((len_inc <= ElemLenW'(2)) && dots_upd)) nx.pending = 1'b1;
            end else begin
              nx.all_dots = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    state_o = nx;
    ok_o = !nx.failed && !nx.pending &&
           (nx.phase == PhBody || nx.phase == PhDone) &&
           (nx.unit_count >= MinCount) && (nx.unit_count != CountSat) &&
           (nx.unit_count <= {1'b0, max_len_i});
  end

endmodule

FILE: rtl/local_path_validator_unit.sv
// top level of the local path validator: input register, path state and verdict register
// Checks one absolute local path per run of code units on the slave stream, tlast on the
// final unit, and returns a single verdict on the master stream (tdata bit 0: 1 = valid).
// One code unit is taken every clock cycle while input is not held back; the final unit sits
// in the input register while the per-unit check logic works on it, and the verdict register
// loads its result when that unit advances. Input is held back only while a verdict waits and
// another final unit is due. max_length is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while no path is in flight, as the block itself does not enforce this.
module local_path_validator_unit import lpv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MaxLenW-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [UnitW-1:0]    s_axis_tdata,   // [15:0] code_unit
  input  logic                s_axis_tlast,   // last_unit
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] path_valid, [7:1] zero
);

  logic [MaxLenW-1:0] max_len_q;
  logic               in_vld_q;
  logic [UnitW-1:0]   in_unit_q;
  logic               in_last_q;
  path_state_t        state_q, state_d;
  logic               out_vld_q;
  logic               out_ok_q;
  logic               ok;
  logic               advance;
  logic               take;

  assign advance       = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  lpv_step u_step (
    .state_i   (state_q),
    .unit_i    (in_unit_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .ok_o      (ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_unit_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // path state returns to its start values after each verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PathStateReset;
    end else if (advance) begin
      state_q <= in_last_q ? PathStateReset : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_ok_q <= ok;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, out_ok_q};

endmodule

FILE: rtl/lpv_checker.sv
// port-level checker for the local path validator, bound to the top level
module lpv_checker import lpv_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // a waiting verdict holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict dropped or changed while stalled");

  // with no verdict waiting the input side is never stalled
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

  // a fresh verdict follows a final-unit transaction
  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("verdict without a final code unit");

  // padding bits of the verdict stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:1] == '0)
    else $error("verdict padding not zero");

endmodule

bind local_path_validator_unit lpv_checker u_lpv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
